// ----- src/u16esc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16esc_pkg
// Shared types and constants for the UTF-16 to escaped text converter.
// ----------------------------------------------------------------------------
package u16esc_pkg;

    localparam logic [15:0] MARK_NATIVE  = 16'hFEFF;
    localparam logic [15:0] MARK_SWAPPED = 16'hFFFE;
    localparam logic [15:0] UNIT_NONCHAR = 16'hFFFF;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_F         = 8'h46;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // last byte index of each kind of run
    localparam logic [2:0] LAST_PLAIN   = 3'd0;
    localparam logic [2:0] LAST_ESCAPE  = 3'd5;
    localparam logic [2:0] LAST_NONCHAR = 3'd7;

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_NONCHAR = 2'd1,
        KIND_ESCAPE  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // one code unit handed from the assembler to the expander
    typedef struct packed {
        logic        valid;
        logic [15:0] unit;
        kind_t       kind;
    } unit_req_t;

    function automatic logic plain_byte(input logic [7:0] b);
        plain_byte = ((b >= 8'h09) && (b <= 8'h0D)) || ((b >= 8'h20) && (b <= 8'h7E));
    endfunction

    function automatic kind_t classify(input logic [15:0] unit);
        kind_t k;
        if ((unit[15:8] == 8'h00) && plain_byte(unit[7:0])) begin
            k = KIND_PLAIN;
        end
        else if (unit == UNIT_NONCHAR) begin
            k = KIND_NONCHAR;
        end
        else if (unit == MARK_NATIVE) begin
            k = KIND_NONE;
        end
        else begin
            k = KIND_ESCAPE;
        end
        classify = k;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'h0, d};
        end
        else begin
            r = 8'h37 + {4'h0, d};
        end
        hex_digit = r;
    endfunction

endpackage

`default_nettype wire

// ----- src/utf16_to_escaped_text.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_escaped_text
// Converts a UTF-16 byte stream into escaped ASCII text.
// ----------------------------------------------------------------------------
// Bytes come in one per request and are paired into 16-bit code units. The
// first unit picks the byte order (FEFF big-endian, FFFE little-endian, any
// other unit is big-endian data) and a mark there is never shown. Each later unit
// becomes one plain ASCII byte, the eight bytes "// FFFF" plus newline for
// FFFF, nothing for FEFF, or \uXXXX with uppercase hex. last_of_run flags the
// final byte of each unit. A lone trailing byte stays held and gives nothing.
// Timing: a unit's text drains from the unit register at one byte per cycle,
// while the output is not stalled, through the result register, so a unit
// holds the input until its last byte moves into the result register. The
// single result channel sets the rate: at most one output byte per cycle.
// The second byte of a unit goes into the unit register, and its first text
// byte then into the result register. The next unit is already taken while the
// last byte of the current one waits in the result register.
// ----------------------------------------------------------------------------
module utf16_to_escaped_text (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte stream in
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    // escaped text out
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run
);
    import u16esc_pkg::*;

    unit_req_t unit_req;
    logic      exp_ready;
    logic      in_accept;

    // stall only while a unit is still draining and cannot retire this cycle
    assign in_stall  = !exp_ready;
    assign in_accept = in_valid && exp_ready;

    // byte pairing, byte order and unit classification
    u16esc_assembler u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_byte (in_byte),
        .req     (unit_req)
    );

    // per-unit text playout into the result register
    u16esc_expander u_expander (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (unit_req),
        .ready       (exp_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ----- src/u16esc_assembler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16esc_assembler
// Pairs incoming bytes into code units, tracks byte order and classifies units.
// ----------------------------------------------------------------------------
module u16esc_assembler (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            in_byte,
    output u16esc_pkg::unit_req_t      req
);
    import u16esc_pkg::*;

    logic       second_byte_due_reg, second_byte_due_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       little_endian_reg, little_endian_next;
    logic       order_known_reg, order_known_next;

    logic [15:0] unit_be;
    logic [15:0] unit_sel;
    kind_t       kind;

    assign unit_be = {held_byte_reg, in_byte};

    always_comb
    begin
        second_byte_due_next = second_byte_due_reg;
        held_byte_next       = held_byte_reg;
        little_endian_next   = little_endian_reg;
        order_known_next     = order_known_reg;
        unit_sel             = unit_be;
        kind                 = KIND_NONE;
        if (accept) begin
            if (!second_byte_due_reg) begin
                held_byte_next       = in_byte;
                second_byte_due_next = 1'b1;
            end
            else begin
                second_byte_due_next = 1'b0;
                if (!order_known_reg) begin
                    order_known_next = 1'b1;
                    if (unit_be == MARK_SWAPPED) begin
                        little_endian_next = 1'b1;
                    end
                    else begin
                        little_endian_next = 1'b0;
                        kind               = classify(unit_be);
                    end
                end
                else begin
                    unit_sel = little_endian_reg ? {in_byte, held_byte_reg} : unit_be;
                    kind     = classify(unit_sel);
                end
            end
        end
    end

    assign req.valid = accept && second_byte_due_reg && (kind != KIND_NONE);
    assign req.unit  = unit_sel;
    assign req.kind  = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            second_byte_due_reg <= 1'b0;
            held_byte_reg       <= 8'h00;
            little_endian_reg   <= 1'b0;
            order_known_reg     <= 1'b0;
        end
        else begin
            second_byte_due_reg <= second_byte_due_next;
            held_byte_reg       <= held_byte_next;
            little_endian_reg   <= little_endian_next;
            order_known_reg     <= order_known_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/u16esc_expander.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16esc_expander
// Holds one classified unit and plays out its text bytes into the result register.
// ----------------------------------------------------------------------------
module u16esc_expander (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire u16esc_pkg::unit_req_t req,
    output logic                       ready,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 out_byte,
    output logic                       last_of_run
);
    import u16esc_pkg::*;

    logic        job_valid_reg, job_valid_next;
    logic [15:0] job_unit_reg;
    kind_t       job_kind_reg;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        load;
    logic        is_last;
    logic        release_job;
    logic [7:0]  cur_byte;

    always_comb
    begin
        cur_byte = CH_BACKSLASH;
        is_last  = 1'b0;
        case (job_kind_reg)
            KIND_PLAIN:
            begin
                cur_byte = job_unit_reg[7:0];
                is_last  = (idx_reg == LAST_PLAIN);
            end
            KIND_NONCHAR:
            begin
                is_last = (idx_reg == LAST_NONCHAR);
                case (idx_reg)
                    3'd0, 3'd1: cur_byte = CH_SLASH;
                    3'd2:       cur_byte = CH_SPACE;
                    3'd7:       cur_byte = CH_NEWLINE;
                    default:    cur_byte = CH_F;
                endcase
            end
            default:
            begin
                is_last = (idx_reg == LAST_ESCAPE);
                case (idx_reg)
                    3'd0:    cur_byte = CH_BACKSLASH;
                    3'd1:    cur_byte = CH_U;
                    3'd2:    cur_byte = hex_digit(job_unit_reg[15:12]);
                    3'd3:    cur_byte = hex_digit(job_unit_reg[11:8]);
                    3'd4:    cur_byte = hex_digit(job_unit_reg[7:4]);
                    default: cur_byte = hex_digit(job_unit_reg[3:0]);
                endcase
            end
        endcase
    end

    assign load        = job_valid_reg && (!out_valid_reg || !out_stall);
    assign release_job = load && is_last;
    assign ready       = !job_valid_reg || release_job;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (load) begin
            idx_next = idx_reg + 3'd1;
        end
        if (release_job) begin
            job_valid_next = 1'b0;
        end
        if (req.valid) begin
            job_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid) begin
            job_unit_reg <= req.unit;
            job_kind_reg <= req.kind;
        end
        if (load) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

// ----- src/u16esc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16esc_checker
// Port-level checks on the escaped text converter.
// ----------------------------------------------------------------------------
module u16esc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run
);
    import u16esc_pkg::*;

    // held input request keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("input request changed while stalled");

    // held result request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("result request changed while stalled");

    // a run continues without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && !out_stall |=> out_valid)
        else $error("gap inside a run");

    // input stall with an empty result register means a byte is coming
    a_stall_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_valid |=> out_valid)
        else $error("input stalled with no output progress");

    // an escape opener is followed by u
    a_escape_u: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run && (out_byte == CH_BACKSLASH)
        |=> out_valid && (out_byte == CH_U))
        else $error("escape not followed by u");

endmodule

bind utf16_to_escaped_text u16esc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-16 to escaped text converter.
// ----------------------------------------------------------------------------
// The byte order is picked at random for each run: a big-endian mark, a
// little-endian mark, or plain data as the first unit. A short table of code
// units covers the field extremes and each kind of unit. Some rows carry the
// text they must produce; the others, and a long random stream of units that
// follows, are checked against a local model of the converter. Both channels
// idle in random bursts. A lone trailing byte closes the stream.
// ----------------------------------------------------------------------------
module testbench;

    import u16esc_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int STREAM_BYTES = 478;
    localparam int CALM_BYTES   = 420;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [15:0] unit;
        bit          typed;
        string       text;
    } unit_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;

    // local copy of the converter state
    bit         pair_open;
    logic [7:0] first_half;
    bit         swap_order;
    bit         order_seen;

    // escaped text still owed by the block, oldest first
    text_char_t pending_text[$];
    text_char_t want;

    int         mismatches;
    int         quiet_cycles;
    int         bytes_sent;
    int         in_gap_pct;
    int         out_gap_pct;
    unit_row_t  dir_rows[11];

    utf16_to_escaped_text uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // text a byte adds to the output, given the current state
    task automatic convert_byte(input logic [7:0] b, output string txt);
        logic [15:0] unit;
        string       digits;
        txt = "";
        if (!pair_open)
        begin
            first_half = b;
            pair_open  = 1'b1;
            return;
        end
        pair_open = 1'b0;
        if (!order_seen)
        begin
            // first unit fixes the order, marks are swallowed
            order_seen = 1'b1;
            unit       = {first_half, b};
            swap_order = (unit == MARK_SWAPPED);
            if ((unit == MARK_NATIVE) || (unit == MARK_SWAPPED))
            begin
                return;
            end
        end
        else
        begin
            unit = swap_order ? {b, first_half} : {first_half, b};
        end
        if ((unit[15:8] == 8'h00) &&
            (((unit[7:0] >= 8'h09) && (unit[7:0] <= 8'h0D)) ||
             ((unit[7:0] >= 8'h20) && (unit[7:0] <= 8'h7E))))
        begin
            txt = $sformatf("%c", unit[7:0]);
        end
        else if (unit == UNIT_NONCHAR)
        begin
            txt = "// FFFF\n";
        end
        else if (unit != MARK_NATIVE)
        begin
            digits = $sformatf("%h", unit);
            txt    = {"\\u", digits.toupper()};
        end
    endtask

    // one request on the input side, then its text is queued
    task automatic send_byte(input logic [7:0] b, input bit typed, input string typed_text);
        string got;
        string owed;
        if ((in_gap_pct != 0) && ($urandom_range(1, 100) <= in_gap_pct))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        convert_byte(b, got);
        owed = typed ? typed_text : got;
        for (int i = 0; i < owed.len(); i++)
        begin
            pending_text.push_back('{owed[i], (i == owed.len() - 1)});
        end
    endtask

    // unit bytes go out in the order the stream has settled on
    task automatic send_unit(input logic [15:0] unit, input bit typed, input string txt);
        if (swap_order)
        begin
            send_byte(unit[7:0], 1'b0, "");
            send_byte(unit[15:8], typed, txt);
        end
        else
        begin
            send_byte(unit[15:8], 1'b0, "");
            send_byte(unit[7:0], typed, txt);
        end
    endtask

    // sender holds off until every owed byte has come out
    task automatic hold_until_drained;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_text.size() != 0);
    endtask

    // receiver stalls in bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && (out_gap_pct != 0) && ($urandom_range(1, 100) <= out_gap_pct))
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each output byte with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_text.size() == 0)
            begin
                $error("out_byte: expected nothing, got %h", out_byte);
                mismatches++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (out_byte !== want.ch)
                begin
                    $error("out_byte: expected %h, got %h", want.ch, out_byte);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int          order_pick;
        int          units_done;
        logic [15:0] unit;

        // outer ends of the plain ranges, their neighbors, and each special unit
        dir_rows = '{
            '{16'h0009,     1'b1, "\t"},
            '{16'h007E,     1'b1, "~"},
            '{16'h0008,     1'b1, "\\u0008"},
            '{16'h007F,     1'b1, "\\u007F"},
            '{16'h0000,     1'b1, "\\u0000"},
            '{16'h00FF,     1'b1, "\\u00FF"},
            '{UNIT_NONCHAR, 1'b1, "// FFFF\n"},
            '{MARK_NATIVE,  1'b1, ""},
            '{MARK_SWAPPED, 1'b1, "\\uFFFE"},
            '{16'h0141,     1'b0, ""},
            '{16'h8000,     1'b0, ""}
        };

        pair_open   = 1'b0;
        first_half  = 8'h00;
        swap_order  = 1'b0;
        order_seen  = 1'b0;
        mismatches  = 0;
        bytes_sent  = 0;
        in_gap_pct  = 10;
        out_gap_pct = 10;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first unit: big-endian mark, little-endian mark, or plain data
        order_pick = $urandom_range(0, 2);
        if (order_pick == 0)
        begin
            send_byte(MARK_NATIVE[15:8], 1'b0, "");
            send_byte(MARK_NATIVE[7:0], 1'b1, "");
        end
        else if (order_pick == 1)
        begin
            send_byte(MARK_SWAPPED[15:8], 1'b0, "");
            send_byte(MARK_SWAPPED[7:0], 1'b1, "");
        end
        else
        begin
            send_byte(8'h00, 1'b0, "");
            send_byte(8'h41, 1'b1, "A");
        end

        foreach (dir_rows[i])
        begin
            send_unit(dir_rows[i].unit, dir_rows[i].typed, dir_rows[i].text);
        end
        hold_until_drained();

        // random stream, mostly whole units with a few stray bytes
        units_done = 0;
        while (bytes_sent < STREAM_BYTES)
        begin
            if ((units_done % 32) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 5;
                    default: in_gap_pct = 25;
                endcase
                case ($urandom_range(0, 2))
                    0: out_gap_pct = 0;
                    1: out_gap_pct = 5;
                    default: out_gap_pct = 20;
                endcase
            end
            if (bytes_sent >= CALM_BYTES)
            begin
                in_gap_pct  = 0;
                out_gap_pct = 0;
            end
            if (units_done == 100)
            begin
                hold_until_drained();
            end

            case ($urandom_range(0, 9))
                0, 1, 2: unit = {8'h00, 8'($urandom_range(8'h20, 8'h7E))};
                3:       unit = {8'h00, 8'($urandom_range(8'h09, 8'h0D))};
                4:       unit = {8'h00, 8'($urandom)};
                5:
                begin
                    case ($urandom_range(0, 2))
                        0: unit = UNIT_NONCHAR;
                        1: unit = MARK_NATIVE;
                        default: unit = MARK_SWAPPED;
                    endcase
                end
                6:       unit = {8'($urandom), 8'($urandom_range(8'h20, 8'h7E))};
                default: unit = 16'($urandom);
            endcase

            // a stray byte shifts the pairing of everything after it
            if ($urandom_range(0, 39) == 0)
            begin
                send_byte(8'($urandom), 1'b0, "");
            end
            send_unit(unit, 1'b0, "");
            units_done++;
        end

        // close on a lone half unit, which must never produce text
        if (pair_open)
        begin
            send_byte(8'($urandom), 1'b0, "");
        end
        send_byte(8'($urandom), 1'b0, "");
        in_valid <= 1'b0;

        while (pending_text.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- utf16_to_escaped_text.f -----
src/u16esc_pkg.sv
src/u16esc_assembler.sv
src/u16esc_expander.sv
src/utf16_to_escaped_text.sv
src/u16esc_checker.sv
tb/testbench.sv
